[design/voxfc_pkg.sv]
// ----------------------------------------------------------------------------
// voxfc_pkg
// Shared field widths, operation, side and face direction codes and the CSR
// map for the voxel face culling block.
// ----------------------------------------------------------------------------
package voxfc_pkg;

   // payload field widths
   localparam int OP_W    = 2;
   localparam int CX_W    = 4;
   localparam int CY_W    = 7;
   localparam int CZ_W    = 4;
   localparam int SIDE_W  = 2;
   localparam int KIND_W  = 8;
   localparam int DIR_W   = 3;
   localparam int NUM_DIR = 6;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE_OWN = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_BND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

   // neighbor sides, also the bit positions of neighbour_present
   localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_FRONT = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_BACK  = 2'd3;

   // face directions, in emit order
   localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd0;
   localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd1;
   localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd2;
   localparam logic [DIR_W-1:0] DIR_POS_X = 3'd3;
   localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd4;
   localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd5;

   // CSR map
   localparam int           CSR_ADDR_W = 3;
   localparam int           CSR_DATA_W = 32;
   localparam int           PRESENT_W  = 4;
   localparam logic [0:0]   REG_NEIGHBOUR_PRESENT = 1'b0;

endpackage

[design/voxfc_if.sv]
// ----------------------------------------------------------------------------
// voxfc_req_if / voxfc_rsp_if
// Valid/ready channels for request words and face record words.
// ----------------------------------------------------------------------------
interface voxfc_req_if import voxfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CX_W-1:0]   cell_x;
   logic [CY_W-1:0]   cell_y;
   logic [CZ_W-1:0]   cell_z;
   logic [SIDE_W-1:0] side;
   logic [KIND_W-1:0] block_kind;

   modport source (output valid, operation, cell_x, cell_y, cell_z, side, block_kind,
                   input ready);
   modport sink   (input valid, operation, cell_x, cell_y, cell_z, side, block_kind,
                   output ready);
endinterface

interface voxfc_rsp_if import voxfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CX_W-1:0]   face_x;
   logic [CY_W-1:0]   face_y;
   logic [CZ_W-1:0]   face_z;
   logic [DIR_W-1:0]  face_dir;
   logic [KIND_W-1:0] face_kind;
   logic              last_face;

   modport source (output valid, face_x, face_y, face_z, face_dir, face_kind, last_face,
                   input ready);
   modport sink   (input valid, face_x, face_y, face_z, face_dir, face_kind, last_face,
                   output ready);
endinterface

[design/voxfc_ram.sv]
// ----------------------------------------------------------------------------
// voxfc_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module voxfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/voxel_face_culling.sv]
// ----------------------------------------------------------------------------
// voxel_face_culling
// Face culling for one voxel chunk. Own cells and the four neighbor boundary
// slices live in two single-port RAMs. A write word (own or boundary) is
// written to its RAM when it is accepted. A query word decides its faces in
// steps: one read of the cell, then one neighbor probe per direction through
// a small sequencer, each neighbor needing at most one RAM read, then a drain
// state to settle the last read. Visible faces then leave one per cycle while
// the result side does not stall, -z,+z,-x,+x,-y,+y, the final one marked
// last_face. A query of an air cell ends after its cell read, and a query of
// a cell outside the chunk ends when it is accepted, without any read.
// The block is not ready while a query is being worked. Neighbors outside the
// chunk height or in an absent neighboring chunk count as air without a read.
// ----------------------------------------------------------------------------
module voxel_face_culling import voxfc_pkg::*; #(
   parameter int CHUNK_WIDTH  = 16,
   parameter int CHUNK_DEPTH  = 16,
   parameter int CHUNK_HEIGHT = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   voxfc_req_if.sink             req_chan,
   voxfc_rsp_if.source           rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int XW      = $clog2(CHUNK_WIDTH);
   localparam int YW      = $clog2(CHUNK_HEIGHT);
   localparam int ZW      = $clog2(CHUNK_DEPTH);
   localparam int LATERAL = (CHUNK_WIDTH > CHUNK_DEPTH) ? CHUNK_WIDTH : CHUNK_DEPTH;
   localparam int LW      = $clog2(LATERAL);
   localparam int OWN_AW  = XW + YW + ZW;
   localparam int BND_AW  = SIDE_W + YW + LW;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CELL  = 5'b00010,
      S_PROBE = 5'b00100,
      S_DRAIN = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic              at_limit;    // above or below the chunk: air
      logic              at_boundary; // neighbor lies in a neighboring chunk
      logic [SIDE_W-1:0] side;
      logic [LW-1:0]     lat;
      logic [XW-1:0]     nx;
      logic [YW-1:0]     ny;
      logic [ZW-1:0]     nz;
   } probe_type;

   // ------------------------------------------------------------------ CSR
   logic [PRESENT_W-1:0] present_ff, present_in;
   logic                 csr_sel_reg;

   assign csr_pready  = 1'b1;
   assign csr_sel_reg = (csr_paddr[CSR_ADDR_W-1] == REG_NEIGHBOUR_PRESENT);

   always_comb begin
      present_in = present_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_reg) begin
         present_in = csr_pwdata[PRESENT_W-1:0];
      end
   end

   assign csr_prdata = csr_sel_reg ? CSR_DATA_W'(present_ff) : '0;

   // ------------------------------------------------------------ registers
   state_type         state_ff, state_in;
   logic [XW-1:0]     qx_ff, qx_in;
   logic [YW-1:0]     qy_ff, qy_in;
   logic [ZW-1:0]     qz_ff, qz_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [DIR_W-1:0]  dir_ff, dir_in;
   logic [NUM_DIR-1:0] mask_ff, mask_in;
   logic              chk_valid_ff, chk_valid_in;
   logic              chk_bnd_ff, chk_bnd_in;
   logic [DIR_W-1:0]  chk_dir_ff, chk_dir_in;

   logic              out_valid_ff, out_valid_in;
   logic [CX_W-1:0]   out_x_ff, out_x_in;
   logic [CY_W-1:0]   out_y_ff, out_y_in;
   logic [CZ_W-1:0]   out_z_ff, out_z_in;
   logic [DIR_W-1:0]  out_dir_ff, out_dir_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic              out_last_ff, out_last_in;

   // ------------------------------------------------------- request decode
   logic accept, x_ok, y_ok, z_ok, cell_ok, bnd_ok;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign x_ok    = 32'(req_chan.cell_x) < 32'(CHUNK_WIDTH);
   assign y_ok    = 32'(req_chan.cell_y) < 32'(CHUNK_HEIGHT);
   assign z_ok    = 32'(req_chan.cell_z) < 32'(CHUNK_DEPTH);
   assign cell_ok = x_ok && y_ok && z_ok;
   assign bnd_ok  = y_ok && ((req_chan.side == SIDE_LEFT || req_chan.side == SIDE_RIGHT)
                             ? z_ok : x_ok);

   // ------------------------------------------------------- neighbor probe
   probe_type         probe;
   logic              probe_present, probe_read, probe_air;

   always_comb begin
      probe             = '0;
      probe.nx          = qx_ff;
      probe.ny          = qy_ff;
      probe.nz          = qz_ff;
      unique case (dir_ff)
         DIR_NEG_Z: begin
            if (qz_ff == '0) begin
               probe.at_boundary = 1'b1;
               probe.side        = SIDE_FRONT;
               probe.lat         = LW'(qx_ff);
            end else begin
               probe.nz = qz_ff - 1'b1;
            end
         end
         DIR_POS_Z: begin
            if (qz_ff == ZW'(CHUNK_DEPTH - 1)) begin
               probe.at_boundary = 1'b1;
               probe.side        = SIDE_BACK;
               probe.lat         = LW'(qx_ff);
            end else begin
               probe.nz = qz_ff + 1'b1;
            end
         end
         DIR_NEG_X: begin
            if (qx_ff == '0) begin
               probe.at_boundary = 1'b1;
               probe.side        = SIDE_LEFT;
               probe.lat         = LW'(qz_ff);
            end else begin
               probe.nx = qx_ff - 1'b1;
            end
         end
         DIR_POS_X: begin
            if (qx_ff == XW'(CHUNK_WIDTH - 1)) begin
               probe.at_boundary = 1'b1;
               probe.side        = SIDE_RIGHT;
               probe.lat         = LW'(qz_ff);
            end else begin
               probe.nx = qx_ff + 1'b1;
            end
         end
         DIR_NEG_Y: begin
            if (qy_ff == '0) begin
               probe.at_limit = 1'b1;
            end else begin
               probe.ny = qy_ff - 1'b1;
            end
         end
         DIR_POS_Y: begin
            if (qy_ff == YW'(CHUNK_HEIGHT - 1)) begin
               probe.at_limit = 1'b1;
            end else begin
               probe.ny = qy_ff + 1'b1;
            end
         end
         default: begin
            probe.at_limit = 1'b1;
         end
      endcase
   end

   assign probe_present = present_ff[probe.side];
   assign probe_read    = !probe.at_limit && (!probe.at_boundary || probe_present);
   assign probe_air     = probe.at_limit || (probe.at_boundary && !probe_present);

   // ----------------------------------------------------------------- RAMs
   logic              own_we, bnd_we;
   logic [OWN_AW-1:0] own_addr;
   logic [BND_AW-1:0] bnd_addr;
   logic [KIND_W-1:0] own_rd, bnd_rd;
   logic [LW-1:0]     req_lat;

   assign req_lat = (req_chan.side == SIDE_LEFT || req_chan.side == SIDE_RIGHT)
                    ? LW'(req_chan.cell_z) : LW'(req_chan.cell_x);

   assign own_we = accept && (req_chan.operation == OP_WRITE_OWN) && cell_ok;
   assign bnd_we = accept && (req_chan.operation == OP_WRITE_BND) && bnd_ok;

   // idle: address from the request word; otherwise from the probe
   always_comb begin
      if (state_ff == S_IDLE) begin
         own_addr = {ZW'(req_chan.cell_z), YW'(req_chan.cell_y), XW'(req_chan.cell_x)};
         bnd_addr = {req_chan.side, YW'(req_chan.cell_y), req_lat};
      end else begin
         own_addr = {probe.nz, probe.ny, probe.nx};
         bnd_addr = {probe.side, qy_ff, probe.lat};
      end
   end

   voxfc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (2 ** OWN_AW)
   ) u_own_ram (
      .clock   (clock),
      .we      (own_we),
      .addr    (own_addr),
      .wr_data (req_chan.block_kind),
      .rd_data (own_rd)
   );

   voxfc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (2 ** BND_AW)
   ) u_bnd_ram (
      .clock   (clock),
      .we      (bnd_we),
      .addr    (bnd_addr),
      .wr_data (req_chan.block_kind),
      .rd_data (bnd_rd)
   );

   // ------------------------------------------------------------ face emit
   logic [DIR_W-1:0]   emit_dir;
   logic [NUM_DIR-1:0] mask_rest;
   logic               out_free;
   logic               chk_air;
   logic [NUM_DIR-1:0] mask_upd;

   always_comb begin
      emit_dir = DIR_NEG_Z;
      for (int i = NUM_DIR - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            emit_dir = DIR_W'(i);
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - 1'b1);
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign chk_air   = chk_valid_ff && ((chk_bnd_ff ? bnd_rd : own_rd) == '0);

   // mask with this cycle's probe and check results folded in
   always_comb begin
      mask_upd = mask_ff;
      if (chk_air) begin
         mask_upd = mask_upd | (NUM_DIR'(1) << chk_dir_ff);
      end
      if (state_ff == S_PROBE && probe_air) begin
         mask_upd = mask_upd | (NUM_DIR'(1) << dir_ff);
      end
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in     = state_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      kind_in      = kind_ff;
      dir_in       = dir_ff;
      mask_in      = mask_upd;
      chk_valid_in = 1'b0;
      chk_bnd_in   = chk_bnd_ff;
      chk_dir_in   = chk_dir_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_dir_in   = out_dir_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            // cell read goes out at the accept edge
            if (accept && req_chan.operation == OP_QUERY && cell_ok) begin
               qx_in    = XW'(req_chan.cell_x);
               qy_in    = YW'(req_chan.cell_y);
               qz_in    = ZW'(req_chan.cell_z);
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            kind_in = own_rd;
            dir_in  = DIR_NEG_Z;
            mask_in = '0;
            state_in = (own_rd == '0) ? S_IDLE : S_PROBE;
         end
         S_PROBE: begin
            chk_valid_in = probe_read;
            chk_bnd_in   = probe.at_boundary;
            chk_dir_in   = dir_ff;
            dir_in       = dir_ff + 1'b1;
            if (dir_ff == DIR_POS_Y) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = (mask_upd == '0) ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = CX_W'(qx_ff);
               out_y_in     = CY_W'(qy_ff);
               out_z_in     = CZ_W'(qz_ff);
               out_dir_in   = emit_dir;
               out_kind_in  = kind_ff;
               out_last_in  = (mask_rest == '0);
               mask_in      = mask_rest;
               if (mask_rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         present_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         out_valid_ff <= out_valid_in;
         present_ff   <= present_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      kind_ff     <= kind_in;
      dir_ff      <= dir_in;
      mask_ff     <= mask_in;
      chk_bnd_ff  <= chk_bnd_in;
      chk_dir_ff  <= chk_dir_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_dir_ff  <= out_dir_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.face_x    = out_x_ff;
   assign rsp_chan.face_y    = out_y_ff;
   assign rsp_chan.face_z    = out_z_ff;
   assign rsp_chan.face_dir  = out_dir_ff;
   assign rsp_chan.face_kind = out_kind_ff;
   assign rsp_chan.last_face = out_last_ff;

   // ----------------------------------------------------------- assertions
   // emit phase always has a face left to send
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> mask_ff != '0)
      else $error("emit phase with empty face mask");

   // a neighbor read in flight only during the probe or drain phase
   assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == S_PROBE || state_ff == S_DRAIN))
      else $error("neighbor check outside probe phase");

   // a non-final face word is taken only while the query is still emitting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_face) |-> state_ff == S_EMIT)
      else $error("non-final face word without a query in progress");

   // a query accepted with the cell in range starts with the cell read
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.operation == OP_QUERY && cell_ok) |=> state_ff == S_CELL)
      else $error("query did not start its cell read");

endmodule
